/* hw/rtl/bdpc_pkg.sv */
package bdpc_pkg;

  // Default width of the stable and hold time counters.
  localparam int unsigned TIME_WIDTH_DEFAULT = 32;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 32;

  // Fixed field widths.
  localparam int unsigned DT_WIDTH   = 16;
  localparam int unsigned MS_WIDTH   = 32;
  localparam int unsigned SECS_WIDTH = 23;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_PROMPT   = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_e;

  // Press event codes.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_CANCEL = 2'd2,
    EV_LONG   = 2'd3
  } press_ev_e;

  // Register reset values and special timing values.
  localparam logic [DT_WIDTH-1:0] DEBOUNCE_RST    = 16'd30;
  localparam logic [MS_WIDTH-1:0] PROMPT_RST      = 32'd1000;
  localparam logic [MS_WIDTH-1:0] LONG_RST        = 32'd3000;
  localparam logic [MS_WIDTH-1:0] DEFAULT_LONG_MS = 32'd3000;
  localparam logic [MS_WIDTH-1:0] LONG_DISABLED   = 32'hFFFF_FFFF;

  // Division by 1000 is a shift by 3 followed by a reciprocal multiply
  // for 125. The multiplier ceil(2^36 / 125) is exact for 29-bit operands.
  localparam int unsigned        PRE_SHIFT   = 3;
  localparam int unsigned        DIV_IN_W    = MS_WIDTH - PRE_SHIFT;
  localparam int unsigned        RECIP_W     = 30;
  localparam int unsigned        RECIP_SHIFT = 36;
  localparam int unsigned        PROD_W      = DIV_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125   = 30'd549755814;

  // Result of the tracking stage, handed to the output stage.
  typedef struct packed {
    press_ev_e           ev;
    logic                pressed;
    logic [MS_WIDTH-1:0] held;
    logic                active;
    logic [MS_WIDTH-1:0] rem_m1;
  } trk_res_t;

endpackage

/* hw/rtl/bdpc_track.sv */
module bdpc_track #(
  parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [bdpc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [bdpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 raw_level_i,
  input  logic [bdpc_pkg::DT_WIDTH-1:0]        elapsed_time_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output bdpc_pkg::trk_res_t                   res_o
);

  localparam logic [TIME_WIDTH-1:0] TimeMax = '1;

  // Configuration registers.
  logic [bdpc_pkg::DT_WIDTH-1:0] debounce_q;
  logic [bdpc_pkg::MS_WIDTH-1:0] prompt_q;
  logic [bdpc_pkg::MS_WIDTH-1:0] long_q;

  // Debounce and hold state.
  logic                  cand_q, cand_d;
  logic [TIME_WIDTH-1:0] stable_q, stable_d;
  logic                  deb_q, deb_d;
  logic [TIME_WIDTH-1:0] hold_q, hold_d;
  logic                  lrep_q, lrep_d;

  // Stage result register.
  logic               res_valid_q;
  bdpc_pkg::trk_res_t res_q, res_d;

  logic                          accept;
  logic                          busy;
  logic [bdpc_pkg::MS_WIDTH-1:0] lng;
  logic [bdpc_pkg::MS_WIDTH-1:0] prm;
  logic [TIME_WIDTH:0]           stable_sum;
  logic [TIME_WIDTH:0]           hold_sum;
  logic [TIME_WIDTH-1:0]         hold_base;
  logic                          lrep_base;
  logic                          flip;
  logic [bdpc_pkg::MS_WIDTH-1:0] hold_ms;
  logic [bdpc_pkg::MS_WIDTH-1:0] hold_n_ms;

  // A new beat enters whenever the stage register is free or drains.
  assign in_ready_o = !res_valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign busy       = cand_q || deb_q;

  // Effective long and prompt times.
  assign lng = (long_q == '0) ? bdpc_pkg::DEFAULT_LONG_MS : long_q;
  assign prm = (prompt_q > lng) ? lng : prompt_q;

  assign hold_ms = bdpc_pkg::MS_WIDTH'(hold_q);

  // Next state and the result for one sample.
  always_comb begin
    res_d      = '0;
    res_d.ev   = bdpc_pkg::EV_NONE;
    cand_d     = raw_level_i;
    stable_sum = {1'b0, stable_q} + (TIME_WIDTH + 1)'(elapsed_time_i);
    if (raw_level_i != cand_q) begin
      stable_d = '0;
    end else if (stable_sum[TIME_WIDTH]) begin
      stable_d = TimeMax;
    end else begin
      stable_d = stable_sum[TIME_WIDTH-1:0];
    end

    // Debounced level follows a candidate that has been stable long enough.
    flip  = (cand_d != deb_q) && (stable_d >= TIME_WIDTH'(debounce_q));
    deb_d = flip ? cand_d : deb_q;
    if (flip && !cand_d && !lrep_q) begin
      res_d.ev = (hold_ms >= prm) ? bdpc_pkg::EV_CANCEL : bdpc_pkg::EV_SHORT;
    end
    hold_base = flip ? '0 : hold_q;
    lrep_base = flip ? 1'b0 : lrep_q;

    // Hold timer runs while pressed; long press is reported once.
    hold_sum  = {1'b0, hold_base} + (TIME_WIDTH + 1)'(elapsed_time_i);
    hold_d    = hold_base;
    lrep_d    = lrep_base;
    if (deb_d) begin
      hold_d = hold_sum[TIME_WIDTH] ? TimeMax : hold_sum[TIME_WIDTH-1:0];
    end
    hold_n_ms = bdpc_pkg::MS_WIDTH'(hold_d);
    if (deb_d && !lrep_base && hold_n_ms >= lng) begin
      lrep_d   = 1'b1;
      res_d.ev = bdpc_pkg::EV_LONG;
    end

    // Prompt window and the remaining time less one for the ceiling divide.
    res_d.pressed = deb_d;
    res_d.held    = deb_d ? hold_n_ms : '0;
    res_d.active  = deb_d && !lrep_d && (lng != bdpc_pkg::LONG_DISABLED) &&
                    (hold_n_ms >= prm) && (hold_n_ms < lng);
    res_d.rem_m1  = lng - hold_n_ms - bdpc_pkg::MS_WIDTH'(1);
  end

  // Configuration writes; prompt and long time writes are dropped while the sampled or debounced level is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bdpc_pkg::DEBOUNCE_RST;
      prompt_q   <= bdpc_pkg::PROMPT_RST;
      long_q     <= bdpc_pkg::LONG_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bdpc_pkg::CFG_DEBOUNCE) begin
        debounce_q <= cfg_data_i[bdpc_pkg::DT_WIDTH-1:0];
      end else if (cfg_index_i == bdpc_pkg::CFG_PROMPT && !busy) begin
        prompt_q <= cfg_data_i;
      end else if (cfg_index_i == bdpc_pkg::CFG_LONG && !busy) begin
        long_q <= cfg_data_i;
      end
    end
  end

  // State and stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q      <= 1'b0;
      stable_q    <= '0;
      deb_q       <= 1'b0;
      hold_q      <= '0;
      lrep_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        res_valid_q <= in_valid_i;
      end
      if (accept) begin
        cand_q   <= cand_d;
        stable_q <= stable_d;
        deb_q    <= deb_d;
        hold_q   <= hold_d;
        lrep_q   <= lrep_d;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/bdpc_result.sv */
module bdpc_result (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  output logic                              res_ready_o,
  input  bdpc_pkg::trk_res_t                res_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        press_event_o,
  output logic                              is_pressed_o,
  output logic [bdpc_pkg::MS_WIDTH-1:0]     held_time_o,
  output logic                              prompt_active_o,
  output logic [bdpc_pkg::SECS_WIDTH-1:0]   seconds_left_o
);

  logic                               out_valid_q;
  logic                               load;
  logic [bdpc_pkg::DIV_IN_W-1:0]      div_in;
  logic [bdpc_pkg::PROD_W-1:0]        prod;
  logic [bdpc_pkg::SECS_WIDTH-1:0]    quot;
  logic [bdpc_pkg::SECS_WIDTH-1:0]    secs_d;
  logic [1:0]                         ev_q;
  logic                               pressed_q;
  logic [bdpc_pkg::MS_WIDTH-1:0]      held_q;
  logic                               active_q;
  logic [bdpc_pkg::SECS_WIDTH-1:0]    secs_q;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  // Whole seconds left, rounded up: floor((rem - 1) / 1000) + 1.
  assign div_in = res_i.rem_m1[bdpc_pkg::MS_WIDTH-1:bdpc_pkg::PRE_SHIFT];
  assign prod   = bdpc_pkg::PROD_W'(div_in) * bdpc_pkg::PROD_W'(bdpc_pkg::RECIP_125);
  assign quot   = prod[bdpc_pkg::RECIP_SHIFT +: bdpc_pkg::SECS_WIDTH];
  assign secs_d = res_i.active ? (quot + bdpc_pkg::SECS_WIDTH'(1)) : '0;

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q      <= res_i.ev;
      pressed_q <= res_i.pressed;
      held_q    <= res_i.held;
      active_q  <= res_i.active;
      secs_q    <= secs_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_event_o   = ev_q;
  assign is_pressed_o    = pressed_q;
  assign held_time_o     = held_q;
  assign prompt_active_o = active_q;
  assign seconds_left_o  = secs_q;

endmodule

/* hw/rtl/button_debounce_press_classifier.sv */
// Button debouncer with short and long press classification.
//
// Input channel (in_valid_i / in_ready_o): one beat per raw button sample,
// carrying the raw level and the milliseconds since the previous sample.
// Output channel (out_valid_o / out_ready_i): exactly one beat per input
// beat, in order: press event, debounced level, hold time, prompt flag and
// whole seconds left until a long press.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 debounce time,
// 1 prompt time, 2 long time; other indexes are ignored. The port is always
// ready. Prompt and long time writes are dropped while the button is down.
//
// Each accepted beat is registered in the tracking stage and then in the
// output stage before it is presented on the output. The state update
// sits in the tracking stage and the divide by 1000 (a reciprocal
// multiply) in the output stage, so one beat per cycle is sustained
// while the receiver is ready. If it stalls, the two registered stages
// fill and in_ready_o drops; nothing is lost or repeated.
// Reset clears all state to not pressed and loads the default timing
// (30 ms debounce, 1000 ms prompt, 3000 ms long); no clearing pass follows.
module button_debounce_press_classifier #(
  parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdpc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [bdpc_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                raw_level_i,
  input  logic [bdpc_pkg::DT_WIDTH-1:0]       elapsed_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          press_event_o,
  output logic                                is_pressed_o,
  output logic [bdpc_pkg::MS_WIDTH-1:0]       held_time_o,
  output logic                                prompt_active_o,
  output logic [bdpc_pkg::SECS_WIDTH-1:0]     seconds_left_o
);

  logic               trk_valid;
  logic               trk_ready;
  bdpc_pkg::trk_res_t trk_res;

  // Configuration writes never stall.
  assign cfg_ready_o = 1'b1;

  // Debounce, hold timing and event classification.
  bdpc_track #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .raw_level_i   (raw_level_i),
    .elapsed_time_i(elapsed_time_i),
    .res_valid_o   (trk_valid),
    .res_ready_i   (trk_ready),
    .res_o         (trk_res)
  );

  // Seconds-left divide and output register.
  bdpc_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (trk_valid),
    .res_ready_o    (trk_ready),
    .res_i          (trk_res),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .press_event_o  (press_event_o),
    .is_pressed_o   (is_pressed_o),
    .held_time_o    (held_time_o),
    .prompt_active_o(prompt_active_o),
    .seconds_left_o (seconds_left_o)
  );

  // The prompt only shows while the button is down and time remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prompt_active_o |-> is_pressed_o && seconds_left_o != '0)
    else $error("prompt active without press or remaining time");

  // Seconds left is reported only with the prompt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seconds_left_o != '0 |-> prompt_active_o)
    else $error("seconds left outside prompt");

  // Release events come with the button up, long press with it down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (press_event_o == bdpc_pkg::EV_SHORT ||
                    press_event_o == bdpc_pkg::EV_CANCEL) |-> !is_pressed_o)
    else $error("release event while pressed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o == bdpc_pkg::EV_LONG |->
      is_pressed_o && !prompt_active_o)
    else $error("long press event while released or prompting");

  // Hold time reads zero when released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_pressed_o |-> held_time_o == '0)
    else $error("hold time nonzero while released");

endmodule
